// File: rtl/jsu_pkg.sv
// Shared types, character codes and helpers for the JSON string unescaper.
// No dependencies; the front end, command queue, back end and top import this package.
package jsu_pkg;

    typedef enum logic [2:0] {
        PH_WAIT = 3'd0,
        PH_STR  = 3'd1,
        PH_ESC  = 3'd2,
        PH_HEX  = 3'd3
    } t_phase;

    typedef enum logic [2:0] {
        ST_DATA   = 3'd0,
        ST_DONE   = 3'd1,
        ST_NOQ    = 3'd2,
        ST_BADESC = 3'd3,
        ST_BADHEX = 3'd4,
        ST_CTRL   = 3'd5,
        ST_EARLY  = 3'd6
    } t_status;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    localparam logic [7:0] BS_CODE = 8'h08;
    localparam logic [7:0] FF_CODE = 8'h0C;
    localparam logic [7:0] LF_CODE = 8'h0A;
    localparam logic [7:0] CR_CODE = 8'h0D;
    localparam logic [7:0] HT_CODE = 8'h09;

    // One queued command: up to three result bytes sharing one status.
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      nres;
        t_status         status;
    } t_cmd;

    // {valid, digit value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    function automatic t_cmd single_cmd(input logic [7:0] b, input t_status st);
        t_cmd c;
        c.bytes  = {8'h00, 8'h00, b};
        c.nres   = 2'd1;
        c.status = st;
        return c;
    endfunction

    function automatic t_cmd utf8_cmd(input logic [15:0] cp);
        t_cmd c;
        c.status = ST_DATA;
        if (cp < 16'h0080) begin
            c.nres  = 2'd1;
            c.bytes = {8'h00, 8'h00, {1'b0, cp[6:0]}};
        end else if (cp < 16'h0800) begin
            c.nres  = 2'd2;
            c.bytes = {8'h00, {2'b10, cp[5:0]}, {3'b110, cp[10:6]}};
        end else begin
            c.nres  = 2'd3;
            c.bytes = {{2'b10, cp[5:0]}, {2'b10, cp[11:6]}, {4'b1110, cp[15:12]}};
        end
        return c;
    endfunction

endpackage

// File: rtl/jsu_if.sv
// Valid/ready channel interfaces for raw input bytes and decoded results.
// Standalone; no package needed.
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       input_end;

    modport source (output valid, output in_byte, output input_end, input ready);
    modport sink   (input valid, input in_byte, input input_end, output ready);
endinterface

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [2:0] status;
    logic       last;

    modport source (output valid, output out_byte, output status, output last, input ready);
    modport sink   (input valid, input out_byte, input status, input last, output ready);
endinterface

// File: rtl/jsu_front.sv
// Front end: accepts raw bytes, tracks string/escape/hex phase, issues commands.
// Depends on jsu_pkg and jsu_in_if.
module jsu_front
    import jsu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    jsu_in_if.sink    i_in,
    input  logic      i_full,
    output logic      o_push,
    output t_cmd      o_cmd
);

    t_phase      r_phase, n_phase;
    logic [1:0]  r_hex_cnt, n_hex_cnt;
    logic [15:0] r_acc, n_acc;

    logic        take;
    logic [4:0]  hex;
    logic [15:0] acc_next;

    assign i_in.ready = !i_full;
    assign take       = i_in.valid && !i_full;
    assign hex        = hex_digit(i_in.in_byte);
    assign acc_next   = {r_acc[11:0], hex[3:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_WAIT;
            r_hex_cnt <= 2'd0;
            r_acc     <= 16'd0;
        end else begin
            r_phase   <= n_phase;
            r_hex_cnt <= n_hex_cnt;
            r_acc     <= n_acc;
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_hex_cnt = r_hex_cnt;
        n_acc     = r_acc;
        o_push    = 1'b0;
        o_cmd     = single_cmd(8'h00, ST_DATA);

        if (take) begin
            if (i_in.input_end) begin
                // end with no string open is silent
                if (r_phase != PH_WAIT) begin
                    n_phase   = PH_WAIT;
                    n_hex_cnt = 2'd0;
                    n_acc     = 16'd0;
                    o_push    = 1'b1;
                    o_cmd     = single_cmd(8'h00, ST_EARLY);
                end
            end else begin
                unique case (r_phase)
                    PH_STR: begin
                        if (i_in.in_byte == CH_QUOTE) begin
                            n_phase = PH_WAIT;
                            o_push  = 1'b1;
                            o_cmd   = single_cmd(8'h00, ST_DONE);
                        end else if (i_in.in_byte == CH_BSLASH) begin
                            n_phase = PH_ESC;
                        end else if (i_in.in_byte < CH_SPACE || i_in.in_byte == CH_DEL) begin
                            n_phase = PH_WAIT;
                            o_push  = 1'b1;
                            o_cmd   = single_cmd(8'h00, ST_CTRL);
                        end else begin
                            o_push = 1'b1;
                            o_cmd  = single_cmd(i_in.in_byte, ST_DATA);
                        end
                    end
                    PH_ESC: begin
                        n_phase = PH_STR;
                        o_push  = 1'b1;
                        unique case (i_in.in_byte) inside
                            CH_QUOTE, CH_BSLASH, CH_SLASH:
                                o_cmd = single_cmd(i_in.in_byte, ST_DATA);
                            CH_B: o_cmd = single_cmd(BS_CODE, ST_DATA);
                            CH_F: o_cmd = single_cmd(FF_CODE, ST_DATA);
                            CH_N: o_cmd = single_cmd(LF_CODE, ST_DATA);
                            CH_R: o_cmd = single_cmd(CR_CODE, ST_DATA);
                            CH_T: o_cmd = single_cmd(HT_CODE, ST_DATA);
                            CH_U: begin
                                n_phase   = PH_HEX;
                                n_hex_cnt = 2'd0;
                                n_acc     = 16'd0;
                                o_push    = 1'b0;
                            end
                            default: begin
                                n_phase = PH_WAIT;
                                o_cmd   = single_cmd(8'h00, ST_BADESC);
                            end
                        endcase
                    end
                    PH_HEX: begin
                        if (!hex[4]) begin
                            n_phase   = PH_WAIT;
                            n_hex_cnt = 2'd0;
                            n_acc     = 16'd0;
                            o_push    = 1'b1;
                            o_cmd     = single_cmd(8'h00, ST_BADHEX);
                        end else if (r_hex_cnt == 2'd3) begin
                            n_phase   = PH_STR;
                            n_hex_cnt = 2'd0;
                            n_acc     = 16'd0;
                            o_push    = 1'b1;
                            o_cmd     = utf8_cmd(acc_next);
                        end else begin
                            n_hex_cnt = r_hex_cnt + 2'd1;
                            n_acc     = acc_next;
                        end
                    end
                    default: begin
                        // waiting for the opening quote
                        if (i_in.in_byte == CH_QUOTE) begin
                            n_phase   = PH_STR;
                            n_hex_cnt = 2'd0;
                            n_acc     = 16'd0;
                        end else begin
                            n_phase   = PH_WAIT;
                            n_hex_cnt = 2'd0;
                            n_acc     = 16'd0;
                            o_push    = 1'b1;
                            o_cmd     = single_cmd(8'h00, ST_NOQ);
                        end
                    end
                endcase
            end
        end
    end

endmodule

// File: rtl/jsu_cmd_fifo.sv
// Short command queue between front and back ends.
// Depends on jsu_pkg.
module jsu_cmd_fifo
    import jsu_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push, do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: rtl/jsu_back.sv
// Back end: walks each queued command into an output register, one result per cycle unless stalled.
// Depends on jsu_pkg and jsu_out_if.
module jsu_back
    import jsu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_cmd      i_cmd,
    output logic      o_pop,
    jsu_out_if.source o_out
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic [2:0] r_status;
    logic       r_last;
    logic [1:0] r_idx;

    logic load, is_last;

    assign load    = !r_valid || o_out.ready;
    assign is_last = (r_idx == i_cmd.nres - 2'd1);
    assign o_pop   = load && i_valid && is_last;

    assign o_out.valid    = r_valid;
    assign o_out.out_byte = r_byte;
    assign o_out.status   = r_status;
    assign o_out.last     = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (load) begin
            r_valid <= i_valid;
            if (i_valid) begin
                // advance within a multi-byte command, rewind at its last result
                r_idx <= is_last ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_byte   <= i_cmd.bytes[r_idx];
            r_status <= i_cmd.status;
            r_last   <= is_last;
        end
    end

endmodule

// File: rtl/json_string_unescape_top.sv
// Top level of the JSON string unescaper: front end, command queue, back end.
// Depends on jsu_pkg, jsu_if, jsu_front, jsu_cmd_fifo and jsu_back.
//
//  Channel  Dir  Payload                       Handshake
//  i_in     in   in_byte[7:0], input_end       valid/ready, sink
//  o_out    out  out_byte[7:0], status[2:0], last  valid/ready, source
//
// One input byte is taken per cycle while the command queue has room.
// Results leave one per cycle while o_out is ready; a \uXXXX escape that encodes to two
// or three UTF-8 bytes holds the back end while it emits each byte, absorbed by the queue.
// A result passes through the command queue and then the back-end output register to o_out.
// Synchronous active-low reset returns to waiting for an opening quote.
// Back-pressure on o_out fills the queue and then drops i_in.ready.
module json_string_unescape_top
    import jsu_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    jsu_in_if.sink    i_in,
    jsu_out_if.source o_out
);

    logic push, full, pop, head_valid;
    t_cmd push_cmd, head_cmd;

    jsu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    jsu_cmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_data  (head_cmd)
    );

    jsu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (head_valid),
        .i_cmd   (head_cmd),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
